/* src/pcrmv_pkg.sv */
// Shared types, widths and constants of the per-channel mean/variance block.
`default_nettype none

package pcrmv_pkg;

   // field widths
   localparam int CHAN_W   = 6;
   localparam int SAMPLE_W = 32;
   localparam int COUNT_W  = 32;
   localparam int MEAN_W   = 32;
   localparam int M2_W     = 63;

   // channel table size and the width that holds its largest value
   localparam int DEFAULT_NUM_CHANNELS = 64;
   localparam int LIMIT_W              = 13;

   // command queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;

   // divider: one quotient bit per step over a 33-bit magnitude
   localparam int DIV_STEPS = 33;
   localparam int DIV_CNT_W = 6;

   localparam logic [M2_W-1:0]    M2_MAX    = {M2_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // what the back part does with a queued word
   typedef enum logic [1:0] {
      OP_ADD,
      OP_READ,
      OP_DROP
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [CHAN_W-1:0]     channel;
      logic [SAMPLE_W-1:0]   sample;
   } cmd_type;

   // one channel record as stored and as returned
   typedef struct packed {
      logic                  valid;
      logic [COUNT_W-1:0]    count;
      logic [MEAN_W-1:0]     mean;
      logic [M2_W-1:0]       m2;
   } rec_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXAM,
      ST_DIV,
      ST_MEAN,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_ACC,
      ST_DONE
   } back_state_type;

endpackage

`default_nettype wire

/* src/pcrmv_front.sv */
// Front part: accepts request words and classifies them into queue commands.
`default_nettype none

module pcrmv_front #(
   parameter int NUM_CHANNELS = pcrmv_pkg::DEFAULT_NUM_CHANNELS
) (
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [pcrmv_pkg::CHAN_W+pcrmv_pkg::SAMPLE_W-1:0] req_word,
   input  wire logic                                   req_action,
   input  wire logic                                   clearing,
   input  wire logic                                   q_full,
   output logic                                        push,
   output pcrmv_pkg::cmd_type                          cmd
);

   logic [pcrmv_pkg::LIMIT_W-1:0] chan_ext;
   logic                          in_range;

   // check the channel against the table size
   assign chan_ext = {{(pcrmv_pkg::LIMIT_W-pcrmv_pkg::CHAN_W){1'b0}},
                      req_word[pcrmv_pkg::CHAN_W-1:0]};
   assign in_range = chan_ext < pcrmv_pkg::LIMIT_W'(NUM_CHANNELS);

   // take a word only when the queue has room and the table is not being cleared
   assign req_tready = !q_full && !clearing;
   assign push       = req_tvalid && req_tready;

   // classify the word
   always_comb begin
      cmd.channel = req_word[pcrmv_pkg::CHAN_W-1:0];
      cmd.sample  = req_word[pcrmv_pkg::CHAN_W+pcrmv_pkg::SAMPLE_W-1:pcrmv_pkg::CHAN_W];
      if (!in_range) begin
         cmd.op = pcrmv_pkg::OP_DROP;
      end else if (req_action) begin
         cmd.op = pcrmv_pkg::OP_READ;
      end else begin
         cmd.op = pcrmv_pkg::OP_ADD;
      end
   end

endmodule

`default_nettype wire

/* src/pcrmv_queue.sv */
// Short command queue that decouples the front part from the back part.
`default_nettype none

module pcrmv_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire pcrmv_pkg::cmd_type  push_cmd,
   input  wire logic                pop,
   output pcrmv_pkg::cmd_type       head,
   output logic                     empty,
   output logic                     full
);

   localparam int PTR_W = (pcrmv_pkg::QUEUE_DEPTH > 1) ? $clog2(pcrmv_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(pcrmv_pkg::QUEUE_DEPTH + 1);

   pcrmv_pkg::cmd_type     slot_ff [pcrmv_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign empty   = cnt_ff == '0;
   assign full    = cnt_ff == CNT_W'(pcrmv_pkg::QUEUE_DEPTH);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(pcrmv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(pcrmv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // store pushed words
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

/* src/pcrmv_back.sv */
// Back part: channel table, serial divider, split multiplier and result register.
`default_nettype none

module pcrmv_back #(
   parameter int NUM_CHANNELS = pcrmv_pkg::DEFAULT_NUM_CHANNELS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire pcrmv_pkg::cmd_type  q_head,
   output logic                     q_pop,
   input  wire logic                out_ready,
   output logic                     out_valid,
   output pcrmv_pkg::rec_type       out_rec,
   output logic                     clearing
);

   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_CHANNELS - 1);
   localparam logic [pcrmv_pkg::DIV_CNT_W-1:0] DIV_LAST =
      pcrmv_pkg::DIV_CNT_W'(pcrmv_pkg::DIV_STEPS - 1);

   pcrmv_pkg::back_state_type state_ff, state_in;

   pcrmv_pkg::rec_type  mem [NUM_CHANNELS];
   pcrmv_pkg::rec_type  rd_ff;
   pcrmv_pkg::rec_type  res_ff;
   pcrmv_pkg::rec_type  out_ff;
   pcrmv_pkg::cmd_type  cmd_ff;

   logic [AW-1:0]                     clr_ff, clr_in;
   logic [pcrmv_pkg::DIV_CNT_W-1:0]   step_ff, step_in;
   logic                              out_valid_ff, out_valid_in;

   logic [pcrmv_pkg::COUNT_W-1:0]     count_ff;
   logic [pcrmv_pkg::MEAN_W-1:0]      mean_ff;
   logic [pcrmv_pkg::M2_W-1:0]        m2_ff;
   logic [32:0]                       delta_ff;
   logic [32:0]                       dvd_ff;
   logic [31:0]                       rem_ff;
   logic [32:0]                       ma_ff, mb_ff;
   logic                              neg_ff;
   logic [48:0]                       pp_lo_ff;
   logic [49:0]                       pp_hi_ff;
   logic [65:0]                       prod_ff;

   logic [pcrmv_pkg::LIMIT_W-1:0]     head_ext, cmd_ext;
   logic [AW-1:0]                     head_addr, cmd_addr;
   logic                              mem_we;
   logic [AW-1:0]                     mem_wa;
   pcrmv_pkg::rec_type                mem_wd;
   logic                              out_load;

   pcrmv_pkg::rec_type                first_rec, acc_rec;
   logic [pcrmv_pkg::COUNT_W-1:0]     n_inc, n_new;
   logic [32:0]                       delta_w, delta_mag, delta_ff_mag;
   logic [32:0]                       div_trial;
   logic                              div_ge;
   logic [31:0]                       rem_next;
   logic [33:0]                       q_signed, mean_sum;
   logic [31:0]                       mean_clamp;
   logic [32:0]                       delta2, delta2_mag;
   logic [pcrmv_pkg::M2_W-1:0]        prod_sat, m2_new;
   logic [63:0]                       m2_sum;

   // table addresses from the queue head and the command in work
   assign head_ext  = {{(pcrmv_pkg::LIMIT_W-pcrmv_pkg::CHAN_W){1'b0}}, q_head.channel};
   assign cmd_ext   = {{(pcrmv_pkg::LIMIT_W-pcrmv_pkg::CHAN_W){1'b0}}, cmd_ff.channel};
   assign head_addr = head_ext[AW-1:0];
   assign cmd_addr  = cmd_ext[AW-1:0];

   // record for the first sample of a channel
   always_comb begin
      first_rec.valid = 1'b1;
      first_rec.count = pcrmv_pkg::COUNT_W'(1);
      first_rec.mean  = cmd_ff.sample;
      first_rec.m2    = '0;
   end

   // count step and first deviation from the stored record
   assign n_inc     = (rd_ff.count != pcrmv_pkg::COUNT_MAX) ? rd_ff.count + 1'b1 : rd_ff.count;
   assign n_new     = (n_inc == '0) ? pcrmv_pkg::COUNT_W'(1) : n_inc;
   assign delta_w   = {cmd_ff.sample[31], cmd_ff.sample} - {rd_ff.mean[31], rd_ff.mean};
   assign delta_mag = delta_w[32] ? 33'd0 - delta_w : delta_w;

   // restoring division: one quotient bit per cycle
   assign div_trial = {rem_ff, dvd_ff[32]};
   assign div_ge    = div_trial >= {1'b0, count_ff};
   always_comb begin
      rem_next = div_trial[31:0];
      if (div_ge) begin
         rem_next = 32'(div_trial - {1'b0, count_ff});
      end
   end

   // new mean (clamped) and second deviation
   assign q_signed = delta_ff[32] ? 34'd0 - {1'b0, dvd_ff} : {1'b0, dvd_ff};
   assign mean_sum = {{2{mean_ff[31]}}, mean_ff} + q_signed;
   always_comb begin
      mean_clamp = mean_sum[31:0];
      if (!mean_sum[33] && (mean_sum[32:31] != 2'b00)) begin
         mean_clamp = 32'h7FFF_FFFF;
      end else if (mean_sum[33] && (mean_sum[32:31] != 2'b11)) begin
         mean_clamp = 32'h8000_0000;
      end
   end
   assign delta2       = {cmd_ff.sample[31], cmd_ff.sample} - {mean_clamp[31], mean_clamp};
   assign delta2_mag   = delta2[32] ? 33'd0 - delta2 : delta2;
   assign delta_ff_mag = delta_ff[32] ? 33'd0 - delta_ff : delta_ff;

   // fold the product into M2 with saturation at the top and a floor at zero
   always_comb begin
      prod_sat = (prod_ff > 66'(pcrmv_pkg::M2_MAX)) ? pcrmv_pkg::M2_MAX : prod_ff[62:0];
      m2_sum   = {1'b0, m2_ff} + {1'b0, prod_sat};
      if (!neg_ff) begin
         m2_new = (m2_sum >= {1'b0, pcrmv_pkg::M2_MAX}) ? pcrmv_pkg::M2_MAX : m2_sum[62:0];
      end else begin
         m2_new = (prod_sat >= m2_ff) ? '0 : m2_ff - prod_sat;
      end
      acc_rec.valid = 1'b1;
      acc_rec.count = count_ff;
      acc_rec.mean  = mean_ff;
      acc_rec.m2    = m2_new;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcrmv_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = pcrmv_pkg::ST_IDLE;
            end
         end
         pcrmv_pkg::ST_IDLE: begin
            if (!q_empty) begin
               state_in = (q_head.op == pcrmv_pkg::OP_DROP) ? pcrmv_pkg::ST_DONE
                                                             : pcrmv_pkg::ST_EXAM;
            end
         end
         pcrmv_pkg::ST_EXAM: begin
            if (cmd_ff.op == pcrmv_pkg::OP_ADD && rd_ff.valid) begin
               state_in = pcrmv_pkg::ST_DIV;
            end else begin
               state_in = pcrmv_pkg::ST_DONE;
            end
         end
         pcrmv_pkg::ST_DIV: begin
            if (step_ff == DIV_LAST) begin
               state_in = pcrmv_pkg::ST_MEAN;
            end
         end
         pcrmv_pkg::ST_MEAN:   state_in = pcrmv_pkg::ST_MUL_LO;
         pcrmv_pkg::ST_MUL_LO: state_in = pcrmv_pkg::ST_MUL_HI;
         pcrmv_pkg::ST_MUL_HI: state_in = pcrmv_pkg::ST_SUM;
         pcrmv_pkg::ST_SUM:    state_in = pcrmv_pkg::ST_ACC;
         pcrmv_pkg::ST_ACC:    state_in = pcrmv_pkg::ST_DONE;
         pcrmv_pkg::ST_DONE: begin
            if (!out_valid_ff || out_ready) begin
               state_in = pcrmv_pkg::ST_IDLE;
            end
         end
         default: state_in = pcrmv_pkg::ST_CLEAR;
      endcase
   end

   // control outputs per state
   always_comb begin
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      mem_wa   = cmd_addr;
      mem_wd   = acc_rec;
      out_load = 1'b0;
      clearing = 1'b0;
      clr_in   = clr_ff;
      step_in  = step_ff;
      case (state_ff)
         pcrmv_pkg::ST_CLEAR: begin
            clearing = 1'b1;
            mem_we   = 1'b1;
            mem_wa   = clr_ff;
            mem_wd   = '0;
            clr_in   = clr_ff + 1'b1;
         end
         pcrmv_pkg::ST_IDLE: begin
            q_pop = !q_empty;
         end
         pcrmv_pkg::ST_EXAM: begin
            step_in = '0;
            if (cmd_ff.op == pcrmv_pkg::OP_ADD && !rd_ff.valid) begin
               mem_we = 1'b1;
               mem_wd = first_rec;
            end
         end
         pcrmv_pkg::ST_DIV: begin
            step_in = step_ff + 1'b1;
         end
         pcrmv_pkg::ST_ACC: begin
            mem_we = 1'b1;
         end
         pcrmv_pkg::ST_DONE: begin
            out_load = !out_valid_ff || out_ready;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // hold a result until the receiver takes it
   assign out_valid_in = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
   assign out_valid    = out_valid_ff;
   assign out_rec      = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcrmv_pkg::ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // channel table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[head_addr];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= res_ff;
      end
      case (state_ff)
         pcrmv_pkg::ST_IDLE: begin
            cmd_ff <= q_head;
            res_ff <= '0;
         end
         pcrmv_pkg::ST_EXAM: begin
            if (cmd_ff.op == pcrmv_pkg::OP_READ) begin
               res_ff <= rd_ff.valid ? rd_ff : '0;
            end else if (!rd_ff.valid) begin
               res_ff <= first_rec;
            end
            count_ff <= n_new;
            mean_ff  <= rd_ff.mean;
            m2_ff    <= rd_ff.m2;
            delta_ff <= delta_w;
            dvd_ff   <= delta_mag;
            rem_ff   <= '0;
         end
         pcrmv_pkg::ST_DIV: begin
            rem_ff <= rem_next;
            dvd_ff <= {dvd_ff[31:0], div_ge};
         end
         pcrmv_pkg::ST_MEAN: begin
            mean_ff <= mean_clamp;
            ma_ff   <= delta_ff_mag;
            mb_ff   <= delta2_mag;
            neg_ff  <= delta_ff[32] != delta2[32];
         end
         pcrmv_pkg::ST_MUL_LO: begin
            pp_lo_ff <= 49'(ma_ff) * 49'(mb_ff[15:0]);
         end
         pcrmv_pkg::ST_MUL_HI: begin
            pp_hi_ff <= 50'(ma_ff) * 50'(mb_ff[32:16]);
         end
         pcrmv_pkg::ST_SUM: begin
            prod_ff <= 66'(pp_lo_ff) + {pp_hi_ff, 16'b0};
         end
         pcrmv_pkg::ST_ACC: begin
            res_ff <= acc_rec;
         end
         default: begin
            res_ff <= res_ff;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/per_channel_running_mean_variance.sv */
// Top level of the per-channel running mean and variance block.
//
// Request channel (req_): one word adds a Q16.16 sample to a channel's
// statistics (req_tuser = 0) or reads the channel's record (req_tuser = 1).
// Response channel (rsp_): exactly one word per request, in request order:
// the channel's record after the update, or all zeros with rsp_tuser clear
// when the channel holds no data or lies beyond the table.
// Path to rsp_tvalid: a read or an add to an empty channel goes through the
// table read and the examine step, an out-of-range word skips both, and an
// add to a channel with data also passes the 33-step serial divider of the
// mean update, the two-step split multiplier and the M2 accumulate.
// The back part works on one word at a time; a two-word queue takes new
// requests while it works, and a result register holds a finished word
// while the next one is computed.
// Reset: the table is swept over its NUM_CHANNELS entries, one entry a cycle;
// req_tready stays low until the sweep ends.
// A stalled receiver holds the result register; the back part then waits
// and the queue fills, after which req_tready drops.
`default_nettype none

module per_channel_running_mean_variance #(
   parameter int NUM_CHANNELS = pcrmv_pkg::DEFAULT_NUM_CHANNELS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [39:0]   req_tdata,   // channel[5:0], sample[37:6], zero pad
   input  wire logic          req_tuser,   // action
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [127:0]       rsp_tdata,   // num_samples[31:0], running_mean[63:32],
                                           // sum_sq_dev[126:64], zero pad
   output logic               rsp_tuser    // record_valid
);

   logic                 push, pop, q_empty, q_full, clearing;
   pcrmv_pkg::cmd_type   push_cmd, head;
   pcrmv_pkg::rec_type   out_rec;

   pcrmv_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_word   (req_tdata[pcrmv_pkg::CHAN_W+pcrmv_pkg::SAMPLE_W-1:0]),
      .req_action (req_tuser),
      .clearing   (clearing),
      .q_full     (q_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   pcrmv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   pcrmv_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (head),
      .q_pop     (pop),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_rec   (out_rec),
      .clearing  (clearing)
   );

   // pack the result word
   assign rsp_tdata = {1'b0, out_rec.m2, out_rec.mean, out_rec.count};
   assign rsp_tuser = out_rec.valid;

   // an empty record goes out as all zeros
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("empty record carries nonzero data");

   // a valid record has at least one sample
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:0] != '0)
      else $error("valid record with zero count");

   // no request is taken while the table is swept
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready)
      else $error("request taken during table sweep");

   // the pad bit above M2 is never set
   a_m2_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[127])
      else $error("pad bit of result word set");

endmodule

`default_nettype wire
